@@ rtl/parallel_input_debouncer_assert.svh @@
// Assertion helpers for the debouncer checker.
`ifndef PARALLEL_INPUT_DEBOUNCER_ASSERT_SVH
`define PARALLEL_INPUT_DEBOUNCER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PID_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("debouncer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("debouncer check failed");

`endif

@@ rtl/pid_pkg.sv @@
package pid_pkg;

	localparam int unsigned SAMPLE_W  = 16;
	localparam int unsigned DB_W      = 3;
	localparam int unsigned WBIT_W    = 4;
	localparam int unsigned LIMIT_W   = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned OUT_TDATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_BITS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_MASK    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WATCH_ENABLE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WATCH_BIT     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WATCH_LIMIT   = 3'd5;

	localparam logic [DB_W-1:0]       RST_DEBOUNCE_BITS = 3'd4;
	localparam logic [SAMPLE_W-1:0]   RST_INVERT_MASK   = 16'h0000;
	localparam logic [SAMPLE_W-1:0]   RST_INPUT_MASK    = 16'hFFFF;
	localparam logic [WBIT_W-1:0]     RST_WATCH_BIT     = 4'd2;
	localparam logic [LIMIT_W-1:0]    RST_WATCH_LIMIT   = 8'd32;
	localparam logic [LIMIT_W-1:0]    LOW_COUNT_MAX     = 8'hFF;

	typedef struct packed {
		logic               enable;
		logic [WBIT_W-1:0]  bit_sel;
		logic [LIMIT_W-1:0] limit;
	} watch_cfg_t;

	typedef struct packed {
		logic                connector_fault;
		logic [SAMPLE_W-1:0] debounced;
	} result_t;

endpackage

@@ rtl/parallel_input_debouncer.sv @@
// Channel   Dir  Handshake          Payload (low bit first)
// s_*       in   s_tvalid/s_tready  s_tdata: raw_sample[15:0]
// m_*       out  m_tvalid/m_tready  m_tdata: debounced[15:0], connector_fault, zero pad
// cfg_*     in   cfg_we             cfg_idx selects register, cfg_data value
//
// One request per clock while s_tready is high: the lane counters, stable levels and
// presence watch all update in the accepting cycle, so throughput is one sample per cycle.
// m_tvalid and m_tdata come from the output register.
// A two-entry output buffer (output register plus skid) takes one more request while
// m_tready is low; s_tready drops only once the skid holds a request.
// arst_n clears counters, stable levels, watch count, fault and config to reset values.
module parallel_input_debouncer #(
	parameter int unsigned LANES       = 16,
	parameter int unsigned COUNT_WIDTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // raw_sample[15:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // debounced[15:0], connector_fault[16], zero[23:17]
	input  logic        cfg_we,
	input  logic [pid_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [pid_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pid_pkg::*;

	// configuration registers
	logic [DB_W-1:0]     debounce_bits_q;
	logic [SAMPLE_W-1:0] invert_mask_q;
	logic [SAMPLE_W-1:0] input_mask_q;
	watch_cfg_t          watch_cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_bits_q     <= RST_DEBOUNCE_BITS;
			invert_mask_q       <= RST_INVERT_MASK;
			input_mask_q        <= RST_INPUT_MASK;
			watch_cfg_q.enable  <= 1'b1;
			watch_cfg_q.bit_sel <= RST_WATCH_BIT;
			watch_cfg_q.limit   <= RST_WATCH_LIMIT;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_DEBOUNCE_BITS: debounce_bits_q     <= cfg_data[DB_W-1:0];
				REG_INVERT_MASK:   invert_mask_q       <= cfg_data;
				REG_INPUT_MASK:    input_mask_q        <= cfg_data;
				REG_WATCH_ENABLE:  watch_cfg_q.enable  <= cfg_data[0];
				REG_WATCH_BIT:     watch_cfg_q.bit_sel <= cfg_data[WBIT_W-1:0];
				REG_WATCH_LIMIT:   watch_cfg_q.limit   <= cfg_data[LIMIT_W-1:0];
				default: ;  // unknown index: drop the write
			endcase
		end
	end

	// Toggle mask: bit 0 always required, bit j required while j < debounce_bits.
	// A zero setting thus acts as one, and settings above the counter width saturate.
	logic [COUNT_WIDTH-1:0] need;
	for (genvar j = 0; j < COUNT_WIDTH; j++) begin : g_need
		if (j == 0) begin : g_first
			assign need[j] = 1'b1;
		end else begin : g_rest
			assign need[j] = (4'(j) < {1'b0, debounce_bits_q});
		end
	end

	logic                accept_in;
	logic                take_out;
	logic [SAMPLE_W-1:0] sample;

	assign accept_in = s_tvalid && s_tready;
	assign take_out  = m_tvalid && m_tready;
	assign sample    = (s_tdata ^ invert_mask_q) & input_mask_q;

	// one counter lane per input bit
	logic [LANES-1:0] stable;
	logic [LANES-1:0] toggle;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		logic lane_sample;
		if (i < SAMPLE_W) begin : g_in
			assign lane_sample = sample[i];
		end else begin : g_pad
			assign lane_sample = 1'b0;
		end
		pid_lane #(
			.COUNT_WIDTH(COUNT_WIDTH)
		) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (accept_in),
			.sample_bit(lane_sample),
			.stable_bit(stable[i]),
			.need      (need),
			.toggle    (toggle[i])
		);
	end

	// fold lane toggles into stable levels and run the presence watch
	result_t step_res;

	pid_merge #(
		.LANES(LANES)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (accept_in),
		.toggle   (toggle),
		.watch_cfg(watch_cfg_q),
		.stable   (stable),
		.result   (step_res)
	);

	// output register plus skid entry
	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;

	assign s_tready = !skid_valid_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W-SAMPLE_W-1){1'b0}}, out_q.connector_fault, out_q.debounced};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || take_out) begin
			// output slot frees up: advance the skid entry or the new request
			out_valid_q  <= skid_valid_q || accept_in;
			skid_valid_q <= 1'b0;
		end else if (accept_in) begin
			// output stalled: park the new request in the skid
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || take_out) begin
			out_q <= skid_valid_q ? skid_q : step_res;
		end else if (accept_in) begin
			skid_q <= step_res;
		end
	end
endmodule

@@ rtl/pid_lane.sv @@
module pid_lane #(
	parameter int unsigned COUNT_WIDTH = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic                   sample_bit,
	input  logic                   stable_bit,
	input  logic [COUNT_WIDTH-1:0] need,
	output logic                   toggle
);
	logic [COUNT_WIDTH-1:0] count_q;
	logic [COUNT_WIDTH-1:0] count_next;
	logic                   delta;

	assign delta      = sample_bit ^ stable_bit;
	// clear on agreement, otherwise count up and wrap
	assign count_next = delta ? count_q + {{(COUNT_WIDTH-1){1'b0}}, 1'b1} : '0;
	assign toggle     = delta && ((count_next & need) == need);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (advance) begin
			count_q <= count_next;
		end
	end
endmodule

@@ rtl/pid_merge.sv @@
module pid_merge #(
	parameter int unsigned LANES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic [LANES-1:0]   toggle,
	input  pid_pkg::watch_cfg_t watch_cfg,
	output logic [LANES-1:0]   stable,
	output pid_pkg::result_t   result
);
	import pid_pkg::*;

	logic [LANES-1:0]    stable_q;
	logic [LANES-1:0]    stable_next;
	logic [SAMPLE_W-1:0] deb_wide;
	logic [LIMIT_W-1:0]  low_cnt_q;
	logic [LIMIT_W-1:0]  low_cnt_next;
	logic                fault_q;
	logic                fault_next;
	logic                watched_high;

	assign stable      = stable_q;
	assign stable_next = stable_q ^ toggle;

	// lanes beyond the sample width never leave zero; missing lanes read low
	for (genvar i = 0; i < SAMPLE_W; i++) begin : g_deb
		if (i < LANES) begin : g_have
			assign deb_wide[i] = stable_next[i];
		end else begin : g_none
			assign deb_wide[i] = 1'b0;
		end
	end

	assign watched_high = deb_wide[watch_cfg.bit_sel];

	always_comb begin
		low_cnt_next = low_cnt_q;
		fault_next   = fault_q;
		if (!watch_cfg.enable || watched_high) begin
			low_cnt_next = '0;
		end else if (low_cnt_q > watch_cfg.limit) begin
			fault_next = 1'b1;
		end else if (low_cnt_q != LOW_COUNT_MAX) begin
			low_cnt_next = low_cnt_q + 8'd1;
		end
	end

	assign result.debounced       = deb_wide;
	assign result.connector_fault = fault_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q  <= '0;
			low_cnt_q <= '0;
			fault_q   <= 1'b0;
		end else if (advance) begin
			stable_q  <= stable_next;
			low_cnt_q <= low_cnt_next;
			fault_q   <= fault_next;
		end
	end
endmodule

@@ rtl/pid_checker.sv @@
`include "parallel_input_debouncer_assert.svh"

module pid_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);
	logic fault_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_seen_q <= 1'b0;
		end else if (m_tvalid && m_tready && m_tdata[16]) begin
			fault_seen_q <= 1'b1;
		end
	end

	// once a fault was delivered every later result carries it
	`PID_ASSERT_NOW(a_fault_sticky, clk, arst_n, m_tvalid && fault_seen_q, m_tdata[16])
	// a stalled result holds
	`PID_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// input backpressure only while a result is pending
	`PID_ASSERT_NOW(a_ready_backpressure, clk, arst_n, !s_tready, m_tvalid)
	// pad bits above the fault flag stay zero
	`PID_ASSERT_NOW(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[23:17] == 7'd0)
endmodule

bind parallel_input_debouncer pid_checker u_pid_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

@@ test/debounce_monitor.sv @@
`timescale 1ns / 1ps

module debounce_monitor (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [15:0]                     s_tdata,   // raw_sample[15:0]
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [23:0]                     m_tdata,   // debounced[15:0], connector_fault, pad
	input  logic                            cfg_we,
	input  logic [pid_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [pid_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                              fail_count,
	output int                              levels_owed
);
	import pid_pkg::*;

	localparam int LANE_COUNT = 16;
	localparam int CNT_BITS   = 4;

	// register copies
	logic [DB_W-1:0]     db_sel;
	logic [SAMPLE_W-1:0] flip_mask;
	logic [SAMPLE_W-1:0] keep_mask;
	watch_cfg_t          watch;

	// lane state
	logic [SAMPLE_W-1:0] levels;
	logic [CNT_BITS-1:0] lane_cnt [LANE_COUNT];
	logic [LIMIT_W-1:0]  low_ticks;
	logic                fault;

	result_t levels_due [$];

	task automatic flag_mismatch(input string what, input logic [23:0] got,
			input logic [23:0] want);
		$display("mismatch at %0t: %s, got %h, want %h", $realtime, what, got, want);
		fail_count++;
	endtask

	// Advance every lane by one sample and the presence watch after it.
	task automatic debounce_tick(input logic [15:0] raw, output result_t res);
		logic [SAMPLE_W-1:0] conditioned;
		logic [SAMPLE_W-1:0] differ;
		logic [SAMPLE_W-1:0] toggle;
		logic [CNT_BITS-1:0] need;
		logic [CNT_BITS-1:0] c;
		int                  width;
		conditioned = (raw ^ flip_mask) & keep_mask;
		differ = conditioned ^ levels;
		width = int'(db_sel);
		if (width < 1)
			width = 1;
		if (width > CNT_BITS)
			width = CNT_BITS;
		need = CNT_BITS'((1 << width) - 1);
		toggle = '0;
		for (int i = 0; i < LANE_COUNT; i++) begin
			if (!differ[i]) begin
				lane_cnt[i] = '0;
			end else begin
				c = lane_cnt[i] + 1'b1;
				lane_cnt[i] = c;
				if ((c & need) == need)
					toggle[i] = 1'b1;
			end
		end
		levels = levels ^ toggle;
		if (watch.enable) begin
			if (levels[watch.bit_sel]) begin
				low_ticks = '0;
			end else if (low_ticks > watch.limit) begin
				fault = 1'b1;
			end else if (low_ticks != LOW_COUNT_MAX) begin
				low_ticks = low_ticks + 1'b1;
			end
		end else begin
			low_ticks = '0;
		end
		res.debounced = levels;
		res.connector_fault = fault;
	endtask

	always @(posedge clk or negedge arst_n) begin : edge_sample
		result_t got;
		result_t want;
		result_t next_res;
		if (!arst_n) begin
			db_sel = RST_DEBOUNCE_BITS;
			flip_mask = RST_INVERT_MASK;
			keep_mask = RST_INPUT_MASK;
			watch.enable = 1'b1;
			watch.bit_sel = RST_WATCH_BIT;
			watch.limit = RST_WATCH_LIMIT;
			levels = '0;
			for (int i = 0; i < LANE_COUNT; i++)
				lane_cnt[i] = '0;
			low_ticks = '0;
			fault = 1'b0;
			levels_due.delete();
			levels_owed = 0;
			fail_count = 0;
		end else begin
			// results first: they belong to older requests than any accepted now
			if (m_tvalid && m_tready) begin
				got = m_tdata[16:0];
				if (levels_due.size() == 0) begin
					flag_mismatch("result with nothing owed", m_tdata, '0);
				end else begin
					want = levels_due.pop_front();
					if (got.debounced !== want.debounced)
						flag_mismatch("debounced", 24'(got.debounced), 24'(want.debounced));
					if (got.connector_fault !== want.connector_fault)
						flag_mismatch("connector_fault", 24'(got.connector_fault),
							24'(want.connector_fault));
					if (m_tdata[23:17] !== '0)
						flag_mismatch("pad bits", 24'(m_tdata[23:17]), '0);
				end
			end
			if (s_tvalid && s_tready) begin
				debounce_tick(s_tdata, next_res);
				levels_due.push_back(next_res);
			end
			if (cfg_we) begin
				case (cfg_idx)
					REG_DEBOUNCE_BITS: db_sel = cfg_data[DB_W-1:0];
					REG_INVERT_MASK:   flip_mask = cfg_data[SAMPLE_W-1:0];
					REG_INPUT_MASK:    keep_mask = cfg_data[SAMPLE_W-1:0];
					REG_WATCH_ENABLE:  watch.enable = cfg_data[0];
					REG_WATCH_BIT:     watch.bit_sel = cfg_data[WBIT_W-1:0];
					REG_WATCH_LIMIT:   watch.limit = cfg_data[LIMIT_W-1:0];
					default: ;
				endcase
			end
			levels_owed = levels_due.size();
		end
	end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import pid_pkg::*;

	// indexes past the register file; writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam int RANDOM_PHASES = 9;
	localparam int PHASE_ITEMS   = 75;
	localparam int CYCLE_LIMIT   = 200000;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [15:0]           s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [23:0]           m_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int fail_count;
	int levels_owed;
	int tx_idle = 0;   // percent of cycles the sender holds off
	int rx_idle = 0;   // percent of cycles the receiver stalls
	int cycles = 0;

	parallel_input_debouncer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	debounce_monitor monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.levels_owed (levels_owed)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Stall the result side at random; hold ready low through reset.
	always @(negedge clk) begin
		m_tready <= arst_n && ($urandom_range(0, 99) >= rx_idle);
	end

	// Fail the run at CYCLE_LIMIT, so a block that stops making progress cannot hang it.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Offer one request, idling first at random. Entered and left at a falling edge;
	// valid stays high across back-to-back requests.
	task automatic offer_sample(input logic [15:0] word);
		while ($urandom_range(0, 99) < tx_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	// Drive one register write; bits above the register width carry junk on purpose.
	// The caller lowers cfg_we after the last write of a batch.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value,
			input int width);
		int unsigned junk;
		junk = $urandom & ~((32'd1 << width) - 1);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= CFG_DATA_W'(junk | value);
		@(negedge clk);
	endtask

	// Write the whole register file plus both spare indexes, then release the port.
	task automatic load_regs(input int unsigned db, input int unsigned inv,
			input int unsigned keep, input int unsigned wen, input int unsigned wbit,
			input int unsigned lim);
		write_reg(REG_DEBOUNCE_BITS, db, DB_W);
		write_reg(REG_INVERT_MASK, inv, SAMPLE_W);
		write_reg(REG_SPARE_LO, $urandom, 0);
		write_reg(REG_INPUT_MASK, keep, SAMPLE_W);
		write_reg(REG_WATCH_ENABLE, wen, 1);
		write_reg(REG_WATCH_BIT, wbit, WBIT_W);
		write_reg(REG_WATCH_LIMIT, lim, LIMIT_W);
		write_reg(REG_SPARE_HI, $urandom, 0);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Drop valid and wait until every request has come back.
	task automatic drain;
		s_tvalid <= 1'b0;
		while (levels_owed != 0)
			@(negedge clk);
	endtask

	// Pick the settings for one random phase. Early phases mask the watched lane
	// with the limit at its top so the low-tick count runs into saturation
	// without faulting; later phases let the sticky fault fire.
	task automatic setup_phase(input int p);
		int unsigned db;
		int unsigned inv;
		int unsigned keep;
		int unsigned wen;
		int unsigned wbit;
		int unsigned lim;
		db = $urandom_range(0, 7);
		inv = $urandom_range(0, 16'hFFFF);
		keep = $urandom_range(0, 16'hFFFF);
		wen = 1;
		wbit = $urandom_range(0, 15);
		lim = $urandom_range(0, 255);
		case (p)
			0: begin
				db = 4;
				inv = 0;
			end
			1: begin
				db = 3;
				wbit = 15;
			end
			2: begin
				db = 1;
				inv = 16'hFFFF;
				keep = 0;
			end
			3: begin
				db = 7;
				wbit = 0;
			end
			4: begin
				db = 2;
				wen = 0;
			end
			5: begin
				db = 5;
				keep = 16'hFFFF;
				lim = $urandom_range(0, 60);
			end
			6: begin
				db = 0;
				lim = 0;
			end
			8: lim = 254;
			default: ;
		endcase
		if (p <= 3) begin
			lim = 255;
			keep = keep & ~(32'd1 << wbit);
		end
		load_regs(db, inv, keep, wen, wbit, lim);
	endtask

	// Mostly held levels with the odd bounce, so lanes stay stable long enough
	// to toggle; a few fully random words break the runs up.
	task automatic run_phase(input int n);
		logic [15:0] target;
		logic [15:0] word;
		target = 16'($urandom);
		repeat (n) begin
			if ($urandom_range(0, 29) == 0)
				target = 16'($urandom);
			else if ($urandom_range(0, 19) == 0)
				target = target ^ (16'd1 << $urandom_range(0, 15));
			word = target;
			if ($urandom_range(0, 3) == 0)
				word = word ^ (16'd1 << $urandom_range(0, 15));
			if ($urandom_range(0, 19) == 0)
				word = 16'($urandom);
			offer_sample(word);
		end
	endtask

	initial begin
		// hold reset low, then release it at a falling edge
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		tx_idle = 36;
		rx_idle = 80;

		// Directed: width 0 acts as 1, so every differing sample toggles at once.
		load_regs(0, 0, 16'hFFFF, 0, 2, 255);
		offer_sample(16'h0000);
		offer_sample(16'hFFFF);
		offer_sample(16'hFFFF);
		offer_sample(16'h0000);
		offer_sample(16'hAAAA);
		offer_sample(16'h5555);
		offer_sample(16'h5555);
		offer_sample(16'h8001);
		offer_sample(16'h7FFE);
		offer_sample(16'hFFFF);
		offer_sample(16'h0000);
		offer_sample(16'h1234);
		drain();

		// Directed: width 7 clamps to the counter width, all inputs inverted,
		// half the lanes masked, watch on the top lane.
		load_regs(7, 16'hFFFF, 16'h0F0F, 1, 15, 255);
		repeat (9) offer_sample(16'h0000);
		offer_sample(16'hFFFF);
		offer_sample(16'h0000);
		offer_sample(16'hF0F0);
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p / 3)
				0: begin
					tx_idle = 36;
					rx_idle = 80;
				end
				1: begin
					tx_idle = 80;
					rx_idle = 36;
				end
				default: begin
					tx_idle = 0;
					rx_idle = 0;
				end
			endcase
			setup_phase(p);
			run_phase(PHASE_ITEMS);
			drain();
		end

		// let any stray result show up before the verdict
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ parallel_input_debouncer.f @@
+incdir+rtl
rtl/pid_pkg.sv
rtl/pid_lane.sv
rtl/pid_merge.sv
rtl/parallel_input_debouncer.sv
rtl/pid_checker.sv
test/debounce_monitor.sv
test/tb.sv
